@@ design/polymorphic_inline_cache_assert.svh @@
// assertion macros for the inline cache
`ifndef POLYMORPHIC_INLINE_CACHE_ASSERT_SVH
`define POLYMORPHIC_INLINE_CACHE_ASSERT_SVH

`ifndef SYNTH
// property holds on every clock edge outside reset
`define PIC_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pic: invariant violated");
// consequent holds in the cycle after the antecedent
`define PIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pic: sequence violated");
`else
`define PIC_ASSERT_ALWAYS(label, clk, rst, prop)
`define PIC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/pic_pkg.sv @@
`timescale 1ns / 1ps

package pic_pkg;

  // cache geometry
  localparam int ENTRIES = 4;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int CLASS_W  = 32;
  localparam int OFFSET_W = 31;
  localparam int FOUND_W  = 32;
  localparam int COUNT_W  = 32;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_UPDATE = 2'd1,
    OP_RESET  = 2'd2
  } op_t;

  // cache modes
  typedef enum logic [2:0] {
    MODE_UNINIT  = 3'd0,
    MODE_MONO    = 3'd1,
    MODE_POLY    = 3'd2,
    MODE_MEGA    = 3'd3,
    MODE_GENERIC = 3'd4
  } mode_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } pic_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } pic_cmd_t;

endpackage

@@ design/polymorphic_inline_cache.sv @@
// result: an accepted transaction is captured, then its result is written to the result register
// from the execute state, or later while an earlier result is still held there by a stall
// flow: no new transaction is accepted while one is executing; the input stalls in the execute
// state, which lasts while the result register is still held by a stall
// reset: synchronous rst clears mode, fill count and counters and sets the threshold to 100;
// entry contents are not cleared
`timescale 1ns / 1ps

module polymorphic_inline_cache (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [pic_pkg::COUNT_W-1:0]        cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         operation,
  input  logic [pic_pkg::CLASS_W-1:0]        class_id,
  input  logic [pic_pkg::OFFSET_W-1:0]       slot_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [pic_pkg::FOUND_W-1:0] found_offset,
  output logic [2:0]                         cache_mode,
  output logic [pic_pkg::COUNT_W-1:0]        hits_so_far,
  output logic [pic_pkg::COUNT_W-1:0]        misses_so_far
);

  pic_pkg::pic_cmd_t cmd;

  // handshake and sequencing
  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // entries, mode, counters and result register
  pic_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .operation        (operation),
    .class_id         (class_id),
    .slot_offset      (slot_offset),
    .hit              (hit),
    .found_offset     (found_offset),
    .cache_mode       (cache_mode),
    .hits_so_far      (hits_so_far),
    .misses_so_far    (misses_so_far)
  );

endmodule

@@ design/pic_ctrl.sv @@
`timescale 1ns / 1ps

module pic_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pic_pkg::pic_cmd_t cmd
);

  pic_pkg::pic_state_t state;
  pic_pkg::pic_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pic_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pic_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pic_pkg::ST_EXEC;
        end
      end
      pic_pkg::ST_EXEC: begin
        if (!out_valid || !out_stall) begin
          state_next = pic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pic_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: capture on accept, commit once the result register is free
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      pic_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pic_pkg::ST_EXEC: begin
        cmd.commit = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/pic_dp.sv @@
`timescale 1ns / 1ps
`include "polymorphic_inline_cache_assert.svh"

module pic_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pic_pkg::pic_cmd_t                 cmd,
  input  logic                              cfg_write_enable,
  input  logic [pic_pkg::COUNT_W-1:0]       cfg_write_data,
  input  logic [1:0]                        operation,
  input  logic [pic_pkg::CLASS_W-1:0]       class_id,
  input  logic [pic_pkg::OFFSET_W-1:0]      slot_offset,
  output logic                              hit,
  output logic signed [pic_pkg::FOUND_W-1:0] found_offset,
  output logic [2:0]                        cache_mode,
  output logic [pic_pkg::COUNT_W-1:0]       hits_so_far,
  output logic [pic_pkg::COUNT_W-1:0]       misses_so_far
);

  // captured transaction
  pic_pkg::op_t                   op;
  logic [pic_pkg::CLASS_W-1:0]    cls;
  logic [pic_pkg::OFFSET_W-1:0]   off;

  // cache state
  logic [pic_pkg::COUNT_W-1:0]    threshold;
  pic_pkg::mode_t                 mode;
  logic [pic_pkg::CNT_W-1:0]      fill_count;
  logic [pic_pkg::COUNT_W-1:0]    hit_counter;
  logic [pic_pkg::COUNT_W-1:0]    miss_counter;
  logic [pic_pkg::CLASS_W-1:0]    entry_class  [pic_pkg::ENTRIES];
  logic [pic_pkg::OFFSET_W-1:0]   entry_offset [pic_pkg::ENTRIES];

  // next values
  pic_pkg::mode_t                 mode_next;
  logic [pic_pkg::CNT_W-1:0]      fill_count_next;
  logic [pic_pkg::COUNT_W-1:0]    hit_counter_next;
  logic [pic_pkg::COUNT_W-1:0]    miss_counter_next;
  logic                           hit_next;
  logic [pic_pkg::FOUND_W-1:0]    found_offset_next;
  logic                           entry_write;
  logic [pic_pkg::IDX_W-1:0]      write_index;

  // compare results
  logic [pic_pkg::ENTRIES-1:0]    match;
  logic                           any_match;
  logic [pic_pkg::IDX_W-1:0]      match_index;
  logic                           lookup_hit;

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= pic_pkg::op_t'(operation);
      cls <= class_id;
      off <= slot_offset;
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= pic_pkg::THRESHOLD_RESET;
    end else if (cfg_write_enable) begin
      threshold <= cfg_write_data;
    end
  end

  // parallel compare against the live entries
  always_comb begin
    for (int i = 0; i < pic_pkg::ENTRIES; i++) begin
      match[i] = (pic_pkg::CNT_W'(i) < fill_count) && (entry_class[i] == cls);
    end
  end

  // lowest matching index wins
  always_comb begin
    match_index = '0;
    for (int i = pic_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_index = pic_pkg::IDX_W'(i);
      end
    end
  end

  assign any_match  = |match;
  assign lookup_hit = any_match &&
                      ((mode == pic_pkg::MODE_MONO) || (mode == pic_pkg::MODE_POLY));
  assign write_index = fill_count[pic_pkg::IDX_W-1:0];

  // step logic
  always_comb begin
    mode_next         = mode;
    fill_count_next   = fill_count;
    hit_counter_next  = hit_counter;
    miss_counter_next = miss_counter;
    hit_next          = 1'b0;
    found_offset_next = '1;
    entry_write       = 1'b0;
    case (op)
      pic_pkg::OP_LOOKUP: begin
        if (lookup_hit) begin
          hit_next          = 1'b1;
          found_offset_next = {1'b0, entry_offset[match_index]};
          if (hit_counter != pic_pkg::COUNT_MAX) begin
            hit_counter_next = hit_counter + 1'b1;
          end
        end else if (miss_counter != pic_pkg::COUNT_MAX) begin
          miss_counter_next = miss_counter + 1'b1;
        end
      end
      pic_pkg::OP_UPDATE: begin
        case (mode)
          pic_pkg::MODE_UNINIT: begin
            entry_write     = 1'b1;
            fill_count_next = pic_pkg::CNT_W'(1);
            mode_next       = pic_pkg::MODE_MONO;
          end
          pic_pkg::MODE_MONO, pic_pkg::MODE_POLY: begin
            // append a new class, or give up once the entries are full
            if (!any_match) begin
              if (fill_count < pic_pkg::CNT_W'(pic_pkg::ENTRIES)) begin
                entry_write     = 1'b1;
                fill_count_next = fill_count + 1'b1;
                mode_next       = pic_pkg::MODE_POLY;
              end else begin
                mode_next = pic_pkg::MODE_MEGA;
              end
            end
          end
          pic_pkg::MODE_MEGA: begin
            if (miss_counter > threshold) begin
              mode_next = pic_pkg::MODE_GENERIC;
            end
          end
          default: begin
            mode_next = mode;
          end
        endcase
      end
      pic_pkg::OP_RESET: begin
        mode_next         = pic_pkg::MODE_UNINIT;
        fill_count_next   = '0;
        hit_counter_next  = '0;
        miss_counter_next = '0;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= pic_pkg::MODE_UNINIT;
      fill_count   <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
    end else if (cmd.commit) begin
      mode         <= mode_next;
      fill_count   <= fill_count_next;
      hit_counter  <= hit_counter_next;
      miss_counter <= miss_counter_next;
    end
  end

  // entry store and result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= hit_next;
      found_offset <= found_offset_next;
      if (entry_write) begin
        entry_class[write_index]  <= cls;
        entry_offset[write_index] <= off;
      end
    end
  end

  assign cache_mode    = mode;
  assign hits_so_far   = hit_counter;
  assign misses_so_far = miss_counter;

  // mode and fill count stay consistent, hits occur only in mono or poly, misses return -1
  `PIC_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= pic_pkg::CNT_W'(pic_pkg::ENTRIES))
  `PIC_ASSERT_ALWAYS(a_mono_fill, clk, rst, (mode != pic_pkg::MODE_MONO) || (fill_count == pic_pkg::CNT_W'(1)))
  `PIC_ASSERT_ALWAYS(a_uninit_empty, clk, rst, (mode != pic_pkg::MODE_UNINIT) || (fill_count == '0))
  `PIC_ASSERT_NEXT(a_hit_mode, clk, rst, cmd.commit && hit_next, (cache_mode == pic_pkg::MODE_MONO) || (cache_mode == pic_pkg::MODE_POLY))
  `PIC_ASSERT_NEXT(a_miss_offset, clk, rst, cmd.commit && !hit_next, found_offset == -1)

endmodule

@@ tb/tb_polymorphic_inline_cache.sv @@
`timescale 1ns / 1ps

module tb_polymorphic_inline_cache;
  import pic_pkg::*;

  localparam logic [1:0]          OP_UNUSED   = 2'd3;
  localparam logic [FOUND_W-1:0]  NO_OFFSET   = '1;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX  = '1;
  localparam int                  CYCLE_LIMIT = 200000;
  localparam int                  PHASES      = 5;
  localparam int                  PHASE_ITEMS = 180;
  localparam int                  POOL_SIZE   = 6;

  // one result of the cache, field by field
  typedef struct packed {
    logic               hit;
    logic [FOUND_W-1:0] found;
    logic [2:0]         mode;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
  } result_t;

  typedef struct {
    logic [1:0]          op;
    logic [CLASS_W-1:0]  cls;
    logic [OFFSET_W-1:0] off;
    bit                  typed;
    result_t             want;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write_enable;
  logic [COUNT_W-1:0]    cfg_write_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            operation;
  logic [CLASS_W-1:0]    class_id;
  logic [OFFSET_W-1:0]   slot_offset;
  logic                  out_valid;
  logic                  out_stall;
  logic                  hit;
  logic signed [FOUND_W-1:0] found_offset;
  logic [2:0]            cache_mode;
  logic [COUNT_W-1:0]    hits_so_far;
  logic [COUNT_W-1:0]    misses_so_far;

  // shadow copy of the cache state
  mode_t               shadow_mode;
  logic [CLASS_W-1:0]  shadow_class [ENTRIES];
  logic [OFFSET_W-1:0] shadow_offset [ENTRIES];
  int                  shadow_fill;
  logic [COUNT_W-1:0]  shadow_hits;
  logic [COUNT_W-1:0]  shadow_misses;
  logic [COUNT_W-1:0]  shadow_threshold;

  result_t             cache_results_due [$];
  directed_row_t       directed_rows [$];
  logic [CLASS_W-1:0]  class_pool [POOL_SIZE];
  bit                  row_is_typed;
  result_t             row_typed_result;
  bit                  idling_on;
  bit [4:0]            modes_reached;
  int                  stall_left;
  int                  fault_count;
  int                  accepted_count;
  int                  hit_results;
  int                  cycle_count;

  polymorphic_inline_cache u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .class_id         (class_id),
    .slot_offset      (slot_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .found_offset     (found_offset),
    .cache_mode       (cache_mode),
    .hits_so_far      (hits_so_far),
    .misses_so_far    (misses_so_far)
  );

  always #5 clk = ~clk;

  // expected outcome of one access, advancing the shadow state
  function automatic result_t predict_cache_access(input logic [1:0] op,
                                                   input logic [CLASS_W-1:0] cls,
                                                   input logic [OFFSET_W-1:0] off);
    result_t res;
    bit      seen;
    int      i;
    res.hit   = 1'b0;
    res.found = NO_OFFSET;
    seen      = 1'b0;
    case (op)
      OP_LOOKUP: begin
        // mono compares entry 0 only, poly the filled entries, lowest index first
        for (i = 0; i < ENTRIES; i++) begin
          if (!seen && p_live(i) && shadow_class[i] == cls) begin
            seen      = 1'b1;
            res.found = {1'b0, shadow_offset[i]};
          end
        end
        res.hit = seen;
        if (seen) begin
          if (shadow_hits != COUNT_MAX) shadow_hits++;
        end else if (shadow_misses != COUNT_MAX) begin
          shadow_misses++;
        end
      end
      OP_UPDATE: begin
        case (shadow_mode)
          MODE_UNINIT: begin
            shadow_class[0]  = cls;
            shadow_offset[0] = off;
            shadow_fill      = 1;
            shadow_mode      = MODE_MONO;
          end
          MODE_MONO: begin
            if (shadow_class[0] != cls) begin
              shadow_class[1]  = cls;
              shadow_offset[1] = off;
              shadow_fill      = 2;
              shadow_mode      = MODE_POLY;
            end
          end
          MODE_POLY: begin
            for (i = 0; i < ENTRIES; i++)
              if (i < shadow_fill && shadow_class[i] == cls) seen = 1'b1;
            if (!seen) begin
              if (shadow_fill < ENTRIES) begin
                shadow_class[shadow_fill]  = cls;
                shadow_offset[shadow_fill] = off;
                shadow_fill++;
              end else begin
                shadow_mode = MODE_MEGA;
              end
            end
          end
          MODE_MEGA: begin
            if (shadow_misses > shadow_threshold) shadow_mode = MODE_GENERIC;
          end
          default: ;
        endcase
      end
      OP_RESET: begin
        shadow_mode   = MODE_UNINIT;
        shadow_fill   = 0;
        shadow_hits   = '0;
        shadow_misses = '0;
      end
      default: ;
    endcase
    res.mode   = shadow_mode;
    res.hits   = shadow_hits;
    res.misses = shadow_misses;
    modes_reached[shadow_mode] = 1'b1;
    return res;
  endfunction

  // entry takes part in a lookup in the current mode
  function automatic bit p_live(input int idx);
    return (shadow_mode == MODE_MONO && idx == 0) ||
           (shadow_mode == MODE_POLY && idx < shadow_fill);
  endfunction

  function automatic void add_directed(input logic [1:0] op, input logic [CLASS_W-1:0] cls,
                                       input logic [OFFSET_W-1:0] off, input bit typed,
                                       input result_t want);
    directed_row_t row;
    row.op    = op;
    row.cls   = cls;
    row.off   = off;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // a fresh handful of classes so that updates reach poly and mega
  function automatic void refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) class_pool[i] = $urandom();
  endfunction

  function automatic logic [CLASS_W-1:0] pick_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return class_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 80) return '0;
    if (r < 85) return '1;
    return $urandom();
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return OFFSET_MAX;
    return OFFSET_W'($urandom());
  endfunction

  // present one transaction and hold it until taken
  task automatic issue_access(input logic [1:0] op, input logic [CLASS_W-1:0] cls,
                              input logic [OFFSET_W-1:0] off, input bit typed,
                              input result_t want);
    if (idling_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    operation        <= op;
    class_id         <= cls;
    slot_offset      <= off;
    row_is_typed     = typed;
    row_typed_result = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cache_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [COUNT_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    shadow_threshold = value;
  endtask

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (!idling_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 12) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // predict on accepted transactions, check returned results
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = predict_cache_access(operation, class_id, slot_offset);
        if (row_is_typed) want = row_typed_result;
        cache_results_due.push_back(want);
        accepted_count++;
      end
      if (out_valid && !out_stall) begin
        if (cache_results_due.size() == 0) begin
          $error("result returned with no transaction outstanding");
          fault_count++;
        end else begin
          want = cache_results_due.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            fault_count++;
          end
          if (found_offset !== want.found) begin
            $error("found_offset: expected %0d, got %0d", $signed(want.found), found_offset);
            fault_count++;
          end
          if (cache_mode !== want.mode) begin
            $error("cache_mode: expected %0d, got %0d", want.mode, cache_mode);
            fault_count++;
          end
          if (hits_so_far !== want.hits) begin
            $error("hits_so_far: expected %0d, got %0d", want.hits, hits_so_far);
            fault_count++;
          end
          if (misses_so_far !== want.misses) begin
            $error("misses_so_far: expected %0d, got %0d", want.misses, misses_so_far);
            fault_count++;
          end
          if (hit === 1'b1) hit_results++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("polymorphic_inline_cache verification failed");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0]  phase_threshold [PHASES];
    logic [1:0]          op;
    logic [CLASS_W-1:0]  cls;
    logic [OFFSET_W-1:0] off;
    int                  r;

    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data   = '0;
    in_valid         = 1'b0;
    operation        = OP_LOOKUP;
    class_id         = '0;
    slot_offset      = '0;
    out_stall        = 1'b0;
    idling_on        = 1'b1;
    stall_left       = 0;
    shadow_mode      = MODE_UNINIT;
    shadow_fill      = 0;
    shadow_hits      = '0;
    shadow_misses    = '0;
    shadow_threshold = THRESHOLD_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_class[i]  = '0;
      shadow_offset[i] = '0;
    end

    // walk through every mode, the field extremes and the unused opcode
    add_directed(OP_LOOKUP, 32'h0000_0000, '0, 1'b1,
                 '{1'b0, NO_OFFSET, MODE_UNINIT, 32'd0, 32'd1});
    add_directed(OP_UPDATE, 32'hFFFF_FFFF, OFFSET_MAX, 1'b1,
                 '{1'b0, NO_OFFSET, MODE_MONO, 32'd0, 32'd1});
    add_directed(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b1,
                 '{1'b1, {1'b0, OFFSET_MAX}, MODE_MONO, 32'd1, 32'd1});
    add_directed(OP_UPDATE, 32'hFFFF_FFFF, '0, 1'b0, '0);
    add_directed(OP_LOOKUP, 32'h0000_0000, '0, 1'b0, '0);
    add_directed(OP_UPDATE, 32'h0000_0000, '0, 1'b0, '0);
    add_directed(OP_LOOKUP, 32'h0000_0000, OFFSET_MAX, 1'b0, '0);
    add_directed(OP_UPDATE, 32'h5A5A_5A5A, 31'h2AAA_AAAA, 1'b0, '0);
    add_directed(OP_UPDATE, 32'hA5A5_A5A5, 31'h5555_5555, 1'b0, '0);
    add_directed(OP_UPDATE, 32'h0000_0000, OFFSET_MAX, 1'b0, '0);
    add_directed(OP_LOOKUP, 32'hA5A5_A5A5, '0, 1'b0, '0);
    add_directed(OP_LOOKUP, 32'h1234_5678, '0, 1'b0, '0);
    add_directed(OP_UPDATE, 32'h1234_5678, 31'h0000_0010, 1'b0, '0);
    add_directed(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0, '0);
    add_directed(OP_UPDATE, 32'h0BAD_F00D, 31'h0000_0020, 1'b0, '0);
    add_directed(OP_LOOKUP, 32'h0000_0000, '0, 1'b0, '0);
    add_directed(OP_UPDATE, 32'h7777_0000, 31'h0000_0030, 1'b0, '0);
    add_directed(OP_UNUSED, 32'h0000_0000, '0, 1'b0, '0);
    add_directed(OP_RESET, 32'h0000_0000, '0, 1'b1,
                 '{1'b0, NO_OFFSET, MODE_UNINIT, 32'd0, 32'd0});
    // entries survive the reset item but must not match in uninit
    add_directed(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b1,
                 '{1'b0, NO_OFFSET, MODE_UNINIT, 32'd0, 32'd1});
    add_directed(OP_UPDATE, 32'h0000_0001, 31'h0000_0001, 1'b0, '0);
    add_directed(OP_UNUSED, 32'hFFFF_FFFF, OFFSET_MAX, 1'b0, '0);

    phase_threshold[0] = 32'd3;
    phase_threshold[1] = $urandom_range(0, 50);
    phase_threshold[2] = THRESHOLD_RESET;
    phase_threshold[3] = '1;
    phase_threshold[4] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // threshold zero lets megamorphic turn generic on the next update
    set_threshold('0);
    foreach (directed_rows[n])
      issue_access(directed_rows[n].op, directed_rows[n].cls, directed_rows[n].off,
                   directed_rows[n].typed, directed_rows[n].want);

    // random phases, each under its own threshold; the last one without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      idling_on = (ph != PHASES - 1);
      set_threshold(phase_threshold[ph]);
      refresh_pool();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r  = $urandom_range(0, 99);
        op = (r < 52) ? OP_LOOKUP : (r < 93) ? OP_UPDATE : (r < 96) ? OP_UNUSED : OP_RESET;
        cls = pick_class();
        off = pick_offset();
        if (ph == 0 && k == PHASE_ITEMS / 2) wait_drained();
        issue_access(op, cls, off, 1'b0, '0);
        if (op == OP_RESET) refresh_pool();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);

    $display("checked %0d transactions, %0d of them lookup hits, under %0d thresholds",
             accepted_count, hit_results, PHASES + 1);
    $display("cache modes reached (generic down to uninit): %b", modes_reached);
    if (fault_count == 0 && cache_results_due.size() == 0) begin
      $display("polymorphic_inline_cache verification clean");
    end else begin
      $display("polymorphic_inline_cache verification failed");
    end
    $finish;
  end

endmodule

@@ polymorphic_inline_cache.f @@
+incdir+design
design/pic_pkg.sv
design/pic_ctrl.sv
design/pic_dp.sv
design/polymorphic_inline_cache.sv
tb/tb_polymorphic_inline_cache.sv
